@@ hdl/antialiased_grid_icon_blend_top_macros.svh @@
// Assertion macros used by the checker in agb_check.sv.
`ifndef ANTIALIASED_GRID_ICON_BLEND_TOP_MACROS_SVH
`define ANTIALIASED_GRID_ICON_BLEND_TOP_MACROS_SVH

// Free-form property, clocked on clk, no reset gating.
`define AGB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("agb assertion failed");

// Same-cycle implication, off while rst is high.
`define AGB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("agb assertion failed");

// Next-cycle implication, off while rst is high.
`define AGB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("agb assertion failed");

`endif

@@ hdl/agb_pkg.sv @@
`default_nettype none

package agb_pkg;

  // Icon geometry, in pixels and half-pixel units
  localparam int SQUARE_SIDE  = 7;
  localparam int SQUARE_GAP   = 4;
  localparam int SQUARE_FAR   = SQUARE_SIDE + SQUARE_GAP;
  localparam int CORNER_R2    = 2;
  localparam int HALF_STROKE2 = 2;

  localparam int PIX_W   = 24;
  localparam int CH_W    = 8;
  localparam int NUM_CH  = 3;
  localparam int COORD_W = 5;
  localparam int POS_W   = COORD_W + 2;

  // Distances carry 7 fractional bits, coverage carries 8
  localparam int Q_FRAC   = 7;
  localparam int COV_FRAC = 8;
  localparam int COV_W    = COV_FRAC + 1;
  localparam int D_W      = 12;

  // Past this many half pixels outside a corner, coverage is always zero
  localparam int EDGE_LIM = CORNER_R2 + HALF_STROKE2 + 1;
  localparam int E_W      = $clog2(EDGE_LIM);
  localparam int NEG_W    = $clog2(SQUARE_SIDE - CORNER_R2 + 1);
  localparam int SQ_W     = $clog2(2 * (EDGE_LIM - 1) * (EDGE_LIM - 1) + 1);
  localparam int ROOT_W   = 10;

  localparam int PROD_W = CH_W + COV_W;

  localparam logic [POS_W-1:0] CTR_NEAR = POS_W'(SQUARE_SIDE);
  localparam logic [POS_W-1:0] CTR_FAR  = POS_W'(2 * SQUARE_FAR + SQUARE_SIDE);
  localparam logic [POS_W:0]   INSET    = (POS_W+1)'(SQUARE_SIDE - CORNER_R2);
  localparam logic [POS_W:0]   EDGE_Q   = (POS_W+1)'(EDGE_LIM);

  localparam logic [D_W-1:0]   CORNER_Q = D_W'(CORNER_R2 << Q_FRAC);
  localparam logic [D_W-1:0]   FADE_HI  = D_W'((HALF_STROKE2 + 1) << Q_FRAC);
  localparam logic [D_W-1:0]   FADE_LO  = D_W'((HALF_STROKE2 - 1) << Q_FRAC);
  localparam logic [COV_W-1:0] COV_FULL = COV_W'(1 << COV_FRAC);
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1 << (COV_FRAC - 1));

  localparam logic [PIX_W-1:0] TINT_RESET = 24'hA3A7B7;

  typedef struct packed {
    logic             big;
    logic [E_W-1:0]   e;
    logic [NEG_W-1:0] n;
  } axis_t;

  typedef struct packed {
    logic                  valid;
    logic [PIX_W-1:0]      bg;
    logic [3:0][COV_W-1:0] cov;
  } cov_beat_t;

  // Split the axis offset from a square into its outside part, its inside
  // part and a flag for points too far out to be touched by the stroke.
  function automatic axis_t axis_of(input logic [POS_W-1:0] p, input logic [POS_W-1:0] c);
    logic [POS_W-1:0] ad;
    logic [POS_W:0]   q;
    axis_t            a;
    ad    = (p >= c) ? p - c : c - p;
    q     = {1'b0, ad} - INSET;
    a.big = 1'b0;
    a.e   = '0;
    a.n   = '0;
    if (q[POS_W]) begin
      a.n = NEG_W'(-q);
    end else if (q >= EDGE_Q) begin
      a.big = 1'b1;
    end else begin
      a.e = E_W'(q);
    end
    return a;
  endfunction

  // round(128 * sqrt(ex^2 + ey^2)) for the offsets that can still give coverage
  function automatic logic [ROOT_W-1:0] sqrt_q7(input logic [E_W-1:0] ex,
                                                input logic [E_W-1:0] ey);
    logic [SQ_W-1:0]   ux;
    logic [SQ_W-1:0]   uy;
    logic [SQ_W-1:0]   s;
    logic [ROOT_W-1:0] r;
    ux = SQ_W'(ex);
    uy = SQ_W'(ey);
    s  = ux * ux + uy * uy;
    case (s)
      6'd0:    r = 10'd0;
      6'd1:    r = 10'd128;
      6'd2:    r = 10'd181;
      6'd4:    r = 10'd256;
      6'd5:    r = 10'd286;
      6'd8:    r = 10'd362;
      6'd9:    r = 10'd384;
      6'd10:   r = 10'd405;
      6'd13:   r = 10'd462;
      6'd16:   r = 10'd512;
      6'd17:   r = 10'd528;
      6'd18:   r = 10'd543;
      6'd20:   r = 10'd572;
      6'd25:   r = 10'd640;
      6'd32:   r = 10'd724;
      default: r = 10'd0;
    endcase
    return r;
  endfunction

  // Stroke coverage of one rounded square, 0..256
  function automatic logic [COV_W-1:0] box_cov(input axis_t x, input axis_t y);
    logic [ROOT_W-1:0] root;
    logic [NEG_W-1:0]  inm;
    logic [D_W-1:0]    d;
    logic [D_W-1:0]    ad;
    logic [COV_W-1:0]  c;
    root = sqrt_q7(x.e, y.e);
    inm  = (x.n < y.n) ? x.n : y.n;
    d    = D_W'(root) - (D_W'(inm) << Q_FRAC) - CORNER_Q;
    ad   = d[D_W-1] ? D_W'(-d) : d;
    if (x.big || y.big || ad >= FADE_HI) begin
      c = '0;
    end else if (ad <= FADE_LO) begin
      c = COV_FULL;
    end else begin
      c = COV_W'(FADE_HI - ad);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hdl/agb_ifs.sv @@
`default_nettype none

interface agb_pix_in_if;
  logic                             valid;
  logic                             ready;
  logic [agb_pkg::COORD_W-1:0]      icon_col;
  logic [agb_pkg::COORD_W-1:0]      icon_row;
  logic [agb_pkg::PIX_W-1:0]        bg_pixel;

  modport source (output valid, output icon_col, output icon_row, output bg_pixel,
                  input ready);
  modport sink (input valid, input icon_col, input icon_row, input bg_pixel,
                output ready);
endinterface

interface agb_pix_out_if;
  logic                             valid;
  logic                             ready;
  logic [agb_pkg::PIX_W-1:0]        out_pixel;
  logic                             covered;

  modport source (output valid, output out_pixel, output covered, input ready);
  modport sink (input valid, input out_pixel, input covered, output ready);
endinterface

interface agb_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [agb_pkg::PIX_W-1:0]        tint_rgb;

  modport source (output valid, output tint_rgb, input ready);
  modport sink (input valid, input tint_rgb, output ready);
endinterface

`default_nettype wire

@@ hdl/agb_geom.sv @@
`default_nettype none

module agb_geom (
  input  logic                clk,
  input  logic                rst,
  agb_pix_in_if.sink          pix_in,
  output agb_pkg::cov_beat_t  beat,
  input  logic                beat_ready
);
  import agb_pkg::*;

  logic                  a_valid;
  axis_t                 a_x [2];
  axis_t                 a_y [2];
  logic [PIX_W-1:0]      a_bg;
  logic                  b_valid;
  logic [PIX_W-1:0]      b_bg;
  logic [3:0][COV_W-1:0] b_cov;
  logic [3:0][COV_W-1:0] cov_next;
  logic                  a_en;
  logic                  b_en;
  logic [POS_W-1:0]      px2;
  logic [POS_W-1:0]      py2;

  assign b_en         = !b_valid || beat_ready;
  assign a_en         = !a_valid || b_en;
  assign pix_in.ready = a_en;

  // pixel center in half-pixel units
  assign px2 = {1'b0, pix_in.icon_col, 1'b1};
  assign py2 = {1'b0, pix_in.icon_row, 1'b1};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_en) begin
      a_valid <= pix_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_en && pix_in.valid) begin
      a_x[0] <= axis_of(px2, CTR_NEAR);
      a_x[1] <= axis_of(px2, CTR_FAR);
      a_y[0] <= axis_of(py2, CTR_NEAR);
      a_y[1] <= axis_of(py2, CTR_FAR);
      a_bg   <= pix_in.bg_pixel;
    end
  end

  always_comb begin
    cov_next[0] = box_cov(a_x[0], a_y[0]);
    cov_next[1] = box_cov(a_x[1], a_y[0]);
    cov_next[2] = box_cov(a_x[1], a_y[1]);
    cov_next[3] = box_cov(a_x[0], a_y[1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_en && a_valid) begin
      b_cov <= cov_next;
      b_bg  <= a_bg;
    end
  end

  assign beat = '{valid: b_valid, bg: b_bg, cov: b_cov};

endmodule

`default_nettype wire

@@ hdl/agb_blend.sv @@
`default_nettype none

module agb_blend (
  input  logic                        clk,
  input  logic                        rst,
  input  agb_pkg::cov_beat_t          beat,
  output logic                        beat_ready,
  input  logic [agb_pkg::PIX_W-1:0]   tint,
  agb_pix_out_if.source               pix_out
);
  import agb_pkg::*;

  logic              c_valid;
  logic [COV_W-1:0]  c_best;
  logic [PIX_W-1:0]  c_bg;
  logic              d_valid;
  logic              d_covered;
  logic [PROD_W-1:0] d_pt [NUM_CH];
  logic [PROD_W-1:0] d_pb [NUM_CH];
  logic              e_valid;
  logic              e_covered;
  logic [PIX_W-1:0]  e_pixel;
  logic [PIX_W-1:0]  pixel_next;
  logic [PROD_W-1:0] sum [NUM_CH];
  logic [COV_W-1:0]  m01;
  logic [COV_W-1:0]  m23;
  logic [COV_W-1:0]  best_next;
  logic [COV_W-1:0]  c_inv;
  logic              c_en;
  logic              d_en;
  logic              e_en;

  assign e_en       = !e_valid || pix_out.ready;
  assign d_en       = !d_valid || e_en;
  assign c_en       = !c_valid || d_en;
  assign beat_ready = c_en;

  // largest coverage of the four squares
  always_comb begin
    m01       = (beat.cov[0] > beat.cov[1]) ? beat.cov[0] : beat.cov[1];
    m23       = (beat.cov[2] > beat.cov[3]) ? beat.cov[2] : beat.cov[3];
    best_next = (m01 > m23) ? m01 : m23;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_en) begin
      c_valid <= beat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_en && beat.valid) begin
      c_best <= best_next;
      c_bg   <= beat.bg;
    end
  end

  assign c_inv = COV_FULL - c_best;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (d_en) begin
      d_valid <= c_valid;
    end
  end

  // zero coverage weighs the background by 256, so it passes through exactly
  always_ff @(posedge clk) begin
    if (d_en && c_valid) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        d_pt[ch] <= PROD_W'(tint[ch*CH_W +: CH_W]) * PROD_W'(c_best);
        d_pb[ch] <= PROD_W'(c_bg[ch*CH_W +: CH_W]) * PROD_W'(c_inv);
      end
      d_covered <= (c_best != '0);
    end
  end

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      sum[ch] = d_pt[ch] + d_pb[ch] + ROUND_HALF;
      pixel_next[ch*CH_W +: CH_W] = sum[ch][COV_FRAC +: CH_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (e_en) begin
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (e_en && d_valid) begin
      e_pixel   <= pixel_next;
      e_covered <= d_covered;
    end
  end

  assign pix_out.valid     = e_valid;
  assign pix_out.out_pixel = e_pixel;
  assign pix_out.covered   = e_covered;

endmodule

`default_nettype wire

@@ hdl/antialiased_grid_icon_blend_top.sv @@
// Grid icon overlay: each transfer on pix_in carries one icon-local pixel
// position and its background color; pix_out returns the color after blending
// toward the tint register by the stroke coverage of the 2x2 rounded-square
// icon, with covered set when any coverage falls on the pixel. One pixel is
// taken every clock while pix_in.ready is high; results leave in order from the
// five register stages (geometry, per-square coverage, coverage maximum, channel
// products, rounded sum). A stall on pix_out holds the result and every full
// stage behind it while empty stages still close up, so pix_in.ready drops only
// once all five stages hold pixels. Write the tint through cfg.tint_rgb while
// no pixels are in flight; cfg.ready is always high.
`default_nettype none

module antialiased_grid_icon_blend_top (
  input  logic           clk,
  input  logic           rst,
  agb_pix_in_if.sink     pix_in,
  agb_pix_out_if.source  pix_out,
  agb_cfg_if.sink        cfg
);
  import agb_pkg::*;

  logic [PIX_W-1:0] tint;
  cov_beat_t        beat;
  logic             beat_ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tint <= TINT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      tint <= cfg.tint_rgb;
    end
  end

  agb_geom u_geom (
    .clk        (clk),
    .rst        (rst),
    .pix_in     (pix_in),
    .beat       (beat),
    .beat_ready (beat_ready)
  );

  agb_blend u_blend (
    .clk        (clk),
    .rst        (rst),
    .beat       (beat),
    .beat_ready (beat_ready),
    .tint       (tint),
    .pix_out    (pix_out)
  );

endmodule

`default_nettype wire

@@ hdl/agb_check.sv @@
`default_nettype none

`include "antialiased_grid_icon_blend_top_macros.svh"

module agb_check (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [agb_pkg::PIX_W-1:0] out_pixel,
  input logic                      covered
);
  logic in_xfer;
  logic out_stall;

  assign in_xfer   = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;

  // pipeline is empty coming out of reset
  `AGB_ASSERT(a_reset_empty, rst |=> !out_valid)
  // a stalled result holds
  `AGB_ASSERT_NXT(a_out_hold, out_stall, out_valid && $stable(out_pixel) && $stable(covered))
  // an open output lets the whole pipeline advance
  `AGB_ASSERT_IMP(a_ready_chain, out_ready, in_ready)
  // an accepted pixel reaches the output while the output keeps draining
  `AGB_ASSERT_NXT(a_latency, in_xfer ##1 out_ready [*4], out_valid)

endmodule

bind antialiased_grid_icon_blend_top agb_check u_agb_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pix_in.valid),
  .in_ready  (pix_in.ready),
  .out_valid (pix_out.valid),
  .out_ready (pix_out.ready),
  .out_pixel (pix_out.out_pixel),
  .covered   (pix_out.covered)
);

`default_nettype wire
